// ----- hdl/newton_square_root_assert.svh -----
// Assertion macros for the checker file nsqrt_chk.sv.
`ifndef NEWTON_SQUARE_ROOT_ASSERT_SVH
`define NEWTON_SQUARE_ROOT_ASSERT_SVH

// same-cycle implication, disabled while rst is high
`define NSQRT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define NSQRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/nsqrt_pkg.sv -----
package nsqrt_pkg;

   localparam int VALUE_WIDTH     = 32;
   localparam int FRAC_BITS       = 16;
   localparam int LIMIT_WIDTH     = 6;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int SQ_WIDTH   = 2 * VALUE_WIDTH;
   // squaring retires two multiplier bits a cycle
   localparam int MUL_DIGITS = VALUE_WIDTH / 2;
   localparam int CNT_WIDTH  = $clog2(VALUE_WIDTH);

   localparam logic [LIMIT_WIDTH-1:0] SMALL_LIMIT_RESET = LIMIT_WIDTH'(10);
   localparam logic [LIMIT_WIDTH-1:0] LARGE_LIMIT_RESET = LIMIT_WIDTH'(50);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SMALL_LIMIT = CSR_INDEX_WIDTH'(0),
      CSR_LARGE_LIMIT = CSR_INDEX_WIDTH'(1)
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CHECK,
      ST_PREP,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

// ----- hdl/nsqrt_if.sv -----
interface nsqrt_req_if import nsqrt_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value_in;

   modport source (output valid, output value_in, input ready);
   modport sink (input valid, input value_in, output ready);
endinterface

interface nsqrt_rsp_if import nsqrt_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] root_out;
   logic [LIMIT_WIDTH-1:0] steps_used;
   logic                   limit_reached;

   modport source (output valid, output root_out, output steps_used, output limit_reached,
                   input ready);
   modport sink (input valid, input root_out, input steps_used, input limit_reached,
                 output ready);
endinterface

interface nsqrt_csr_if import nsqrt_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [LIMIT_WIDTH-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/newton_square_root.sv -----
// Newton-Raphson square root of an unsigned Q16.16 word.
// req_if carries the operand word, rsp_if returns the root, the step count and
// a flag set when the step limit, not convergence, ended the iteration.
// csr_if writes the two step limits (index 0: operand below one, index 1:
// operand one or above); it is always ready and should be used only when idle.
// A zero operand goes straight to the output register. Otherwise each step is a
// radix-4 squaring followed by a restoring division, both on one shared shift
// datapath; a step whose quotient overflows skips the division.
// One word is in flight at a time; a new request is taken as soon as the
// previous result has been moved into the output register.
// If the receiver stalls, the response is held and a second finished result
// waits in the datapath until the output register frees up.
// Reset (synchronous) empties the block and restores limits 10 and 50.
module newton_square_root import nsqrt_pkg::*; (
   input logic        clock,
   input logic        reset,
   nsqrt_req_if.sink   req_if,
   nsqrt_rsp_if.source rsp_if,
   nsqrt_csr_if.sink   csr_if
);

   state_type state_ff, state_in;

   logic [LIMIT_WIDTH-1:0] small_limit_ff, small_limit_in;
   logic [LIMIT_WIDTH-1:0] large_limit_ff, large_limit_in;

   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] g_ff, g_in;
   logic [SQ_WIDTH-1:0]    p_ff, p_in;
   logic [VALUE_WIDTH:0]   rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dq_ff, dq_in;
   logic                   ovf_ff, ovf_in;
   logic                   ge_ff, ge_in;
   logic                   small_ff, small_in;
   logic                   hit_ff, hit_in;
   logic [LIMIT_WIDTH-1:0] steps_ff, steps_in;
   logic [LIMIT_WIDTH-1:0] limit_ff, limit_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_root_ff, rsp_root_in;
   logic [LIMIT_WIDTH-1:0] rsp_steps_ff, rsp_steps_in;
   logic                   rsp_hit_ff, rsp_hit_in;

   logic req_take;
   logic out_load;

   // check-stage compare
   logic [SQ_WIDTH-1:0]    target;
   logic [SQ_WIDTH:0]      diff_up;
   logic [SQ_WIDTH-1:0]    diff_dn;
   logic [SQ_WIDTH-1:0]    diff_sel;
   logic                   sq_ge;
   logic                   cond;
   logic                   at_limit;
   logic                   stop;

   // shared shift datapath
   logic [VALUE_WIDTH:0]   divisor;
   logic [VALUE_WIDTH+1:0] pp;
   logic [VALUE_WIDTH+1:0] trial;
   logic                   qbit;
   logic [VALUE_WIDTH:0]   sum;

   assign req_take = req_if.valid && (state_ff == ST_IDLE);
   assign out_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   assign target  = {{(SQ_WIDTH-VALUE_WIDTH-FRAC_BITS){1'b0}}, n_ff, {FRAC_BITS{1'b0}}};
   assign diff_up = {1'b0, p_ff} - {1'b0, target};
   assign diff_dn = target - p_ff;
   assign sq_ge   = !diff_up[SQ_WIDTH];
   assign diff_sel = sq_ge ? diff_up[SQ_WIDTH-1:0] : diff_dn;
   // below one: square still under 1.0; otherwise square still above n
   assign cond     = small_ff ? (p_ff[SQ_WIDTH-1:2*FRAC_BITS] == '0)
                              : (sq_ge && (diff_up[SQ_WIDTH-1:0] != '0));
   assign at_limit = (steps_ff >= limit_ff);
   assign stop     = !cond || at_limit || (g_ff == '0);

   assign divisor = {g_ff, 1'b0};
   assign pp      = {2'b00, p_ff[SQ_WIDTH-1:VALUE_WIDTH]}
                  + (p_ff[0] ? {2'b00, g_ff} : '0)
                  + (p_ff[1] ? {1'b0, g_ff, 1'b0} : '0);
   assign trial   = {rem_ff, dq_ff[VALUE_WIDTH-1]} - {1'b0, divisor};
   assign qbit    = !trial[VALUE_WIDTH+1];
   assign sum     = {1'b0, g_ff} + {1'b0, dq_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_if.value_in == '0) ? ST_FINISH : ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (cnt_ff == CNT_WIDTH'(MUL_DIGITS-1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stop ? ST_FINISH : ST_PREP;
         end
         ST_PREP: begin
            state_in = (rem_ff >= divisor) ? ST_UPDATE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (cnt_ff == CNT_WIDTH'(VALUE_WIDTH-1)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_SQUARE;
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      n_in     = n_ff;
      g_in     = g_ff;
      p_in     = p_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      ovf_in   = ovf_ff;
      ge_in    = ge_ff;
      small_in = small_ff;
      hit_in   = hit_ff;
      steps_in = steps_ff;
      limit_in = limit_ff;
      cnt_in   = cnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               n_in     = req_if.value_in;
               g_in     = req_if.value_in;
               p_in     = {{VALUE_WIDTH{1'b0}}, req_if.value_in};
               small_in = (req_if.value_in != '0)
                          && (req_if.value_in[VALUE_WIDTH-1:FRAC_BITS] == '0);
               limit_in = ((req_if.value_in != '0)
                           && (req_if.value_in[VALUE_WIDTH-1:FRAC_BITS] == '0))
                          ? small_limit_ff : large_limit_ff;
               steps_in = '0;
               hit_in   = 1'b0;
               cnt_in   = '0;
            end
         end
         ST_SQUARE: begin
            p_in   = {pp, p_ff[VALUE_WIDTH-1:2]};
            cnt_in = cnt_ff + CNT_WIDTH'(1);
         end
         ST_CHECK: begin
            hit_in = cond && at_limit;
            ge_in  = sq_ge;
            rem_in = {1'b0, diff_sel[SQ_WIDTH-1:VALUE_WIDTH]};
            dq_in  = diff_sel[VALUE_WIDTH-1:0];
         end
         ST_PREP: begin
            // quotient of 2^VALUE_WIDTH or more swamps any guess
            ovf_in = (rem_ff >= divisor);
            cnt_in = '0;
         end
         ST_DIVIDE: begin
            rem_in = qbit ? trial[VALUE_WIDTH:0] : {rem_ff[VALUE_WIDTH-1:0], dq_ff[VALUE_WIDTH-1]};
            dq_in  = {dq_ff[VALUE_WIDTH-2:0], qbit};
            cnt_in = cnt_ff + CNT_WIDTH'(1);
         end
         ST_UPDATE: begin
            if (ge_ff) begin
               g_in = (ovf_ff || (dq_ff > g_ff)) ? '0 : (g_ff - dq_ff);
            end else begin
               g_in = (ovf_ff || sum[VALUE_WIDTH]) ? '1 : sum[VALUE_WIDTH-1:0];
            end
            p_in     = {{VALUE_WIDTH{1'b0}}, g_in};
            steps_in = steps_ff + LIMIT_WIDTH'(1);
            cnt_in   = '0;
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // output register and limit registers
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_root_in  = rsp_root_ff;
      rsp_steps_in = rsp_steps_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_root_in  = g_ff;
         rsp_steps_in = steps_ff;
         rsp_hit_in   = hit_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      small_limit_in = small_limit_ff;
      large_limit_in = large_limit_ff;
      if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_SMALL_LIMIT: small_limit_in = csr_if.data;
            CSR_LARGE_LIMIT: large_limit_in = csr_if.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         small_limit_ff <= SMALL_LIMIT_RESET;
         large_limit_ff <= LARGE_LIMIT_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         small_limit_ff <= small_limit_in;
         large_limit_ff <= large_limit_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      g_ff         <= g_in;
      p_ff         <= p_in;
      rem_ff       <= rem_in;
      dq_ff        <= dq_in;
      ovf_ff       <= ovf_in;
      ge_ff        <= ge_in;
      small_ff     <= small_in;
      hit_ff       <= hit_in;
      steps_ff     <= steps_in;
      limit_ff     <= limit_in;
      cnt_ff       <= cnt_in;
      rsp_root_ff  <= rsp_root_in;
      rsp_steps_ff <= rsp_steps_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   assign req_if.ready         = (state_ff == ST_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.root_out      = rsp_root_ff;
   assign rsp_if.steps_used    = rsp_steps_ff;
   assign rsp_if.limit_reached = rsp_hit_ff;
   assign csr_if.ready         = 1'b1;

endmodule

// ----- hdl/nsqrt_chk.sv -----
`include "newton_square_root_assert.svh"

module nsqrt_chk import nsqrt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [VALUE_WIDTH-1:0] rsp_root_out,
   input logic [LIMIT_WIDTH-1:0] rsp_steps_used,
   input logic                   rsp_limit_reached
);

   // a stalled response word holds
   `NSQRT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_root_out) && $stable(rsp_steps_used) && $stable(rsp_limit_reached), "stalled response changed")

   // one word in flight: request side closes right after a take
   `NSQRT_ASSERT_NEXT(a_one_inflight, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // no response can appear in the cycle straight after a take
   `NSQRT_ASSERT_NEXT(a_min_latency, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "response too early")

   // reset leaves the block empty and open for requests
   `NSQRT_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && req_ready, "bad state after reset")

endmodule

bind newton_square_root nsqrt_chk u_nsqrt_chk (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_if.valid),
   .req_ready         (req_if.ready),
   .rsp_valid         (rsp_if.valid),
   .rsp_ready         (rsp_if.ready),
   .rsp_root_out      (rsp_if.root_out),
   .rsp_steps_used    (rsp_if.steps_used),
   .rsp_limit_reached (rsp_if.limit_reached)
);
